// ----- hdl/ftoi_pkg.sv -----
// Package for the saturating float-to-integer converter.
// Holds mode codes, field widths and the channel payload types. No dependencies.
package ftoi_pkg;

  localparam int ModeWidth   = 2;
  localparam int ValueWidth  = 64;
  localparam int ResultWidth = 64;

  // Conversion mode codes
  localparam logic [ModeWidth-1:0] MODE_S_TO_32 = 2'd0;
  localparam logic [ModeWidth-1:0] MODE_S_TO_64 = 2'd1;
  localparam logic [ModeWidth-1:0] MODE_D_TO_32 = 2'd2;
  localparam logic [ModeWidth-1:0] MODE_D_TO_64 = 2'd3;

  localparam logic [63:0] MAX_I64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_I64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_I32 = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] MIN_I32 = 64'hFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic [ModeWidth-1:0]  mode;
    logic [ValueWidth-1:0] value_bits;
  } in_item_t;

  typedef struct packed {
    logic signed [ResultWidth-1:0] int_result;
  } out_item_t;

endpackage

// ----- hdl/ftoi_in_if.sv -----
// Input and output channel interfaces for the converter.
// Depends on ftoi_pkg for the payload types.
interface ftoi_in_if;
  import ftoi_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ftoi_out_if;
  import ftoi_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/fp_to_int_saturating_convert.sv -----
// Top level of the saturating IEEE-754 to signed integer converter.
// Depends on ftoi_pkg and the channel interfaces in ftoi_in_if.sv.
//
// Usage:
//   in_ch  carries mode and value_bits; a transaction completes when valid
//          and ready are both high at a rising clk edge.
//   out_ch carries int_result with the same handshake.
// Each item is captured in an input register, decoded and shifted by one
// pass of combinational logic, and written to a result register.
// Throughput: one item per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input
// register keeps one more item; in_ch.ready drops only while both are full.
// Reset (rst, synchronous, active high) empties both stages; no other state.
// NaN gives zero, infinities and out-of-range values saturate by sign,
// everything else is truncated toward zero.
module fp_to_int_saturating_convert (
  input logic      clk,
  input logic      rst,
  ftoi_in_if.sink  in_ch,
  ftoi_out_if.source out_ch
);
  import ftoi_pkg::*;

  logic     in_valid;
  in_item_t in_reg;
  logic     out_valid;
  logic [63:0] out_reg;
  logic     advance;

  // Stage moves when result register is empty or being drained
  assign advance      = !out_valid || out_ch.ready;
  assign in_ch.ready  = !in_valid || advance;
  assign out_ch.valid = out_valid;
  assign out_ch.data.int_result = out_reg;

  // Decode fields
  logic        dbl, to64, neg, exp_all1, frac_nz;
  logic [63:0] raw;
  logic [10:0] expf;
  logic [51:0] frac;
  logic [52:0] sig;
  logic signed [12:0] e;
  logic [5:0]  top;
  logic [63:0] sat, mag, conv;

  always_comb begin
    dbl  = in_reg.mode[1];
    to64 = in_reg.mode[0];
    raw  = dbl ? in_reg.value_bits : {32'd0, in_reg.value_bits[31:0]};
    if (dbl) begin
      neg      = raw[63];
      expf     = raw[62:52];
      frac     = raw[51:0];
      exp_all1 = &raw[62:52];
      e        = $signed({2'b00, raw[62:52]}) - 13'sd1023;
    end else begin
      neg      = raw[31];
      expf     = {3'd0, raw[30:23]};
      frac     = {raw[22:0], 29'd0};
      exp_all1 = &raw[30:23];
      e        = $signed({5'd0, raw[30:23]}) - 13'sd127;
    end
    frac_nz = |frac;
    // Single fraction is left-aligned to the double position
    sig  = {1'b1, frac};
    top  = to64 ? 6'd63 : 6'd31;
    sat  = to64 ? (neg ? MIN_I64 : MAX_I64) : (neg ? MIN_I32 : MAX_I32);
    mag  = 64'd0;
    if (e >= 13'sd52) begin
      mag = {11'd0, sig} << e[5:0] - 6'd52;
    end else if (e >= 13'sd0) begin
      mag = {11'd0, sig} >> (6'd52 - e[5:0]);
    end
    if (exp_all1) begin
      conv = frac_nz ? 64'd0 : sat;
    end else if (expf == 11'd0 || e < 13'sd0) begin
      conv = 64'd0;
    end else if (e >= $signed({7'd0, top})) begin
      conv = sat;
    end else begin
      conv = neg ? (64'd0 - mag) : mag;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_reg <= in_ch.data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_reg <= conv;
    end
  end

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_reg))
    else $error("result changed while stalled");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    in_valid && advance |=> out_valid)
    else $error("item lost between stages");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> in_valid && out_valid)
    else $error("ready low with space available");
  a_nan: assert property (@(posedge clk) disable iff (rst)
    in_valid && exp_all1 && frac_nz && advance |=> out_reg == 64'd0)
    else $error("NaN not converted to zero");
`endif

endmodule

// ----- dv/testbench.sv -----
// Testbench for fp_to_int_saturating_convert: random and directed conversions
// checked against an in-bench predictor. Depends on ftoi_pkg and the channel interfaces.
`timescale 1ns / 1ps
module testbench;
  import ftoi_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ftoi_in_if  in_ch ();
  ftoi_out_if out_ch ();

  fp_to_int_saturating_convert u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  in_item_t    pending_items[$];
  logic [63:0] expected_ints[$];
  int          send_idle_pct = 14;
  int          recv_idle_pct = 81;
  bit          failed = 1'b0;

  // Truncate toward zero and saturate by sign; NaN converts to zero
  function automatic logic [63:0] convert_to_int(input logic [1:0] mode,
                                                 input logic [63:0] bits);
    logic        to64;
    logic        dbl;
    int          frac_w;
    int          exp_val;
    int          bias;
    int          top;
    logic        neg;
    logic [63:0] raw;
    logic [63:0] expf;
    logic [63:0] exp_max;
    logic [63:0] frac;
    logic [63:0] sat;
    logic [63:0] mag;
    to64   = (mode == MODE_S_TO_64) || (mode == MODE_D_TO_64);
    dbl    = (mode == MODE_D_TO_32) || (mode == MODE_D_TO_64);
    frac_w = dbl ? 52 : 23;
    bias   = dbl ? 1023 : 127;
    raw    = dbl ? bits : {32'd0, bits[31:0]};
    exp_max = dbl ? 64'h7FF : 64'hFF;
    neg    = dbl ? raw[63] : raw[31];
    expf   = (raw >> frac_w) & exp_max;
    frac   = raw & ((64'd1 << frac_w) - 64'd1);
    top    = to64 ? 63 : 31;
    if (neg) sat = to64 ? MIN_I64 : MIN_I32;
    else sat = to64 ? MAX_I64 : MAX_I32;
    if (expf == exp_max) return (frac != 0) ? 64'd0 : sat;
    if (expf == 0) return 64'd0;
    exp_val = int'(expf) - bias;
    if (exp_val < 0) return 64'd0;
    if (exp_val >= top) return sat;
    mag = frac | (64'd1 << frac_w);
    if (exp_val >= frac_w) mag = mag << (exp_val - frac_w);
    else mag = mag >> (frac_w - exp_val);
    return neg ? (64'd0 - mag) : mag;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Build a value near the conversion boundary for the chosen source format
  function automatic logic [63:0] near_range(input logic [1:0] mode);
    logic [63:0] v;
    v = rand64();
    if (mode[1]) begin
      v[62:52] = 11'd1023 + 11'($urandom_range(0, 66)) - 11'd3;
    end else begin
      v[62:32] = 31'd0;
      v[30:23] = 8'd127 + 8'($urandom_range(0, 66)) - 8'd3;
      if ($urandom_range(0, 1)) v[63:32] = $urandom();
    end
    return v;
  endfunction

  task automatic add_item(input logic [1:0] mode, input logic [63:0] bits);
    in_item_t it;
    it.mode = mode;
    it.value_bits = bits;
    pending_items.push_back(it);
  endtask

  // Driver: present the next item, advance on transaction
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_ints.push_back(
          convert_to_int(in_ch.data.mode, in_ch.data.value_bits));
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= pending_items.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_ints.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_ch.data.int_result);
          failed = 1'b1;
        end else begin
          logic [63:0] want;
          want = expected_ints.pop_front();
          if (out_ch.data.int_result !== want) begin
            $display("%0t: int_result expected %h actual %h", $time, want,
                     out_ch.data.int_result);
            failed = 1'b1;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    // Directed: zeros, NaN, infinities, range edges, subnormals, ignored upper bits
    for (int m = 0; m < 4; m++) begin
      add_item(2'(m), m[1] ? 64'h8000_0000_0000_0000 : 64'hFFFF_FFFF_8000_0000);
      add_item(2'(m), m[1] ? 64'hFFF8_0000_0000_0001 : 64'h0000_0000_FFC0_0001);
      add_item(2'(m), m[1] ? 64'h7FF0_0000_0000_0000 : 64'h0000_0000_7F80_0000);
      add_item(2'(m), m[1] ? 64'hFFF0_0000_0000_0000 : 64'h1234_5678_FF80_0000);
      add_item(2'(m), m[1] ? 64'hC1E0_0000_0000_0000 : 64'h0000_0000_CF00_0000);
      add_item(2'(m), m[1] ? 64'hC3E0_0000_0000_0000 : 64'h0000_0000_DF00_0000);
      add_item(2'(m), m[1] ? 64'h000F_FFFF_FFFF_FFFF : 64'hFFFF_FFFF_BF7F_FFFF);
    end
    add_item(MODE_D_TO_64, 64'h43DF_FFFF_FFFF_FFFF);
    add_item(MODE_D_TO_32, 64'h41DF_FFFF_FFC0_0000);
    add_item(MODE_S_TO_64, 64'hFFFF_FFFF_3FC0_0000);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // Random: three idling phases; mix of boundary, raw and special values
    for (int ph = 0; ph < 3; ph++) begin
      for (int i = 0; i < 480; i++) begin
        logic [1:0]  mode;
        logic [63:0] v;
        mode = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
          0, 1:    v = rand64();
          2: begin
            v = rand64();
            if (mode[1]) v[62:52] = '1;
            else v[30:23] = '1;
          end
          3: begin
            v = rand64();
            if (mode[1]) v[62:52] = '0;
            else v[30:23] = '0;
          end
          default: v = near_range(mode);
        endcase
        add_item(mode, v);
      end
      while (pending_items.size() > 0 || in_ch.valid || expected_ints.size() > 0)
        @(posedge clk);
      repeat (5) @(posedge clk);
      if (ph == 0) begin
        send_idle_pct = 81;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end
    if (!failed) begin
      $display("[fp_to_int_saturating_convert] OK");
    end else begin
      $display("[fp_to_int_saturating_convert] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[fp_to_int_saturating_convert] ERROR");
    $finish;
  end
endmodule
